FILE: sv/rotation_to_euler_zyx_defines.svh
// ----------------------------------------------------------------------------
// rotation_to_euler_zyx_defines
// assertion macros shared by the euler extraction block
// ----------------------------------------------------------------------------
`ifndef ROTATION_TO_EULER_ZYX_DEFINES_SVH
`define ROTATION_TO_EULER_ZYX_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// types, constants and arctangent table for the euler extraction block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rte_pkg;

  localparam int ROT_W = 16;
  localparam int POS_W = 32;
  localparam int ANG_W = 16;
  localparam int Z_W = 32;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_MATRIX_FRAC_BITS = 14;
  localparam logic [Z_W-1:0] Z_PI = 32'h8000_0000;
  localparam logic [Z_W-1:0] Z_HALF_LSB = 32'h0000_8000;

  typedef struct packed {
    logic signed [ROT_W-1:0] rot_00;
    logic signed [ROT_W-1:0] rot_10;
    logic signed [ROT_W-1:0] rot_20;
    logic signed [ROT_W-1:0] rot_21;
    logic signed [ROT_W-1:0] rot_22;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } rte_payload_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } rte_pos_t;

  // arctangent of 2^-i, 2^32 = 2 pi
  function automatic logic [Z_W-1:0] atan_entry(input int idx);
    logic [Z_W-1:0] v;
    case (idx)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/rte_if.sv
// ----------------------------------------------------------------------------
// rte_if
// valid/ready channels for pose input and euler result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rte_in_if import rte_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [ROT_W-1:0] rot_00;
  logic signed [ROT_W-1:0] rot_10;
  logic signed [ROT_W-1:0] rot_20;
  logic signed [ROT_W-1:0] rot_21;
  logic signed [ROT_W-1:0] rot_22;
  logic signed [POS_W-1:0] pos_x_in;
  logic signed [POS_W-1:0] pos_y_in;
  logic signed [POS_W-1:0] pos_z_in;
  modport source (output valid, rot_00, rot_10, rot_20, rot_21, rot_22,
                  pos_x_in, pos_y_in, pos_z_in, input ready);
  modport sink (input valid, rot_00, rot_10, rot_20, rot_21, rot_22,
                pos_x_in, pos_y_in, pos_z_in, output ready);
endinterface

interface rte_out_if import rte_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [ANG_W-1:0] roll_out;
  logic signed [ANG_W-1:0] pitch_out;
  logic signed [ANG_W-1:0] yaw_out;
  logic signed [POS_W-1:0] pos_x_out;
  logic signed [POS_W-1:0] pos_y_out;
  logic signed [POS_W-1:0] pos_z_out;
  logic chose_first;
  modport source (output valid, roll_out, pitch_out, yaw_out, pos_x_out, pos_y_out,
                  pos_z_out, chose_first, input ready);
  modport sink (input valid, roll_out, pitch_out, yaw_out, pos_x_out, pos_y_out,
                pos_z_out, chose_first, output ready);
endinterface

FILE: sv/rte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rte_sqrt_cell
// one digit of the integer square root, with the transaction payload alongside
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rte_sqrt_cell import rte_pkg::*; #(
  parameter int FRAC = DEF_MATRIX_FRAC_BITS,
  parameter int K = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*FRAC+1:0]   rem_in,
  input  logic [2*FRAC+1:0]   res_in,
  input  rte_payload_t        pay_in,
  output logic [2*FRAC+1:0]   rem_r,
  output logic [2*FRAC+1:0]   res_r,
  output rte_payload_t        pay_r
);

  localparam int RW = 2*FRAC + 2;
  localparam logic [RW-1:0] BIT = RW'(1) << (2*(FRAC-K));

  logic [RW-1:0] trial;
  logic [RW-1:0] rem_nxt;
  logic [RW-1:0] res_nxt;

  // restoring step for this digit
  always_comb begin
    trial = res_in + BIT;
    if (rem_in >= trial) begin
      rem_nxt = rem_in - trial;
      res_nxt = (res_in >> 1) + BIT;
    end else begin
      rem_nxt = rem_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
      pay_r <= pay_in;
    end
  end

endmodule

FILE: sv/rte_cordic_cell.sv
// ----------------------------------------------------------------------------
// rte_cordic_cell
// one vectoring micro-rotation of the arctangent chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rte_cordic_cell import rte_pkg::*; #(
  parameter int W = 36,
  parameter int I = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic [Z_W-1:0]      z_in,
  input  logic                zero_in,
  output logic signed [W-1:0] x_r,
  output logic signed [W-1:0] y_r,
  output logic [Z_W-1:0]      z_r,
  output logic                zero_r
);

  localparam logic [Z_W-1:0] ATAN = atan_entry(I);

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] x_nxt;
  logic signed [W-1:0] y_nxt;
  logic [Z_W-1:0]      z_nxt;

  // rotate towards the x axis
  always_comb begin
    xs = x_in >>> I;
    ys = y_in >>> I;
    if (!y_in[W-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      zero_r <= zero_in;
    end
  end

endmodule

FILE: sv/rotation_to_euler_zyx.sv
// ----------------------------------------------------------------------------
// rotation_to_euler_zyx
// zyx roll-pitch-yaw extraction from a rotation matrix with pose pass-through
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle while the output is not stalled and returns
// one result per transaction, in order. The pipeline is an input register, a chain
// of square-root digit cells (MATRIX_FRAC_BITS + 1 of them), six parallel CORDIC
// chains of CORDIC_STAGES cells and an output register. A stall on the output holds
// the whole pipeline.
`timescale 1ns / 1ps
`include "rotation_to_euler_zyx_defines.svh"

module rotation_to_euler_zyx import rte_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int MATRIX_FRAC_BITS = DEF_MATRIX_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  rte_in_if.sink      in_ch,
  rte_out_if.source   out_ch
);

  localparam int F = MATRIX_FRAC_BITS;
  localparam int N = CORDIC_STAGES;
  localparam int DW = 2*F + 1;
  localparam int RW = 2*F + 2;
  localparam int SQW = (DW > 32) ? DW : 32;
  localparam int OPW = (F + 2 > ROT_W + 1) ? F + 2 : ROT_W + 1;
  localparam int W = OPW + 16 + 3;
  localparam int L = F + 2 + N;
  localparam int LANES = 6;

  logic adv;
  logic [L-1:0] vld_r;
  logic out_valid_r;

  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_ch.valid};
    end
  end

  // input stage: squared pitch sine and saturated difference
  logic signed [2*ROT_W-1:0] sq;
  logic [SQW-1:0] sq_ext;
  logic [SQW-1:0] one2;
  logic [DW-1:0] d_r;
  rte_payload_t pay_r;

  always_comb begin
    sq = (2*ROT_W)'(in_ch.rot_20) * (2*ROT_W)'(in_ch.rot_20);
    sq_ext = SQW'($unsigned(sq));
    one2 = SQW'(1) << (2*F);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= (sq_ext >= one2) ? '0 : DW'(one2 - sq_ext);
      pay_r.rot_00 <= in_ch.rot_00;
      pay_r.rot_10 <= in_ch.rot_10;
      pay_r.rot_20 <= in_ch.rot_20;
      pay_r.rot_21 <= in_ch.rot_21;
      pay_r.rot_22 <= in_ch.rot_22;
      pay_r.pos_x <= in_ch.pos_x_in;
      pay_r.pos_y <= in_ch.pos_y_in;
      pay_r.pos_z <= in_ch.pos_z_in;
    end
  end

  // square-root digit chain
  logic [RW-1:0] rem_w [F+2];
  logic [RW-1:0] res_w [F+2];
  rte_payload_t pay_w [F+2];

  assign rem_w[0] = RW'(d_r);
  assign res_w[0] = '0;
  assign pay_w[0] = pay_r;

  for (genvar k = 0; k <= F; k++) begin : g_sqrt
    rte_sqrt_cell #(.FRAC(F), .K(k)) u_cell (
      .clk(clk), .en(adv),
      .rem_in(rem_w[k]), .res_in(res_w[k]), .pay_in(pay_w[k]),
      .rem_r(rem_w[k+1]), .res_r(res_w[k+1]), .pay_r(pay_w[k+1])
    );
  end

  // lane operands: pitch one, pitch two, roll one, roll two, yaw one, yaw two
  rte_payload_t sp;
  logic signed [OPW-1:0] c_s;
  logic signed [OPW-1:0] r00_s, r10_s, r20_s, r21_s, r22_s;
  logic signed [OPW-1:0] ly [LANES];
  logic signed [OPW-1:0] lx [LANES];

  always_comb begin
    sp = pay_w[F+1];
    c_s = $signed(OPW'(res_w[F+1]));
    r00_s = OPW'(sp.rot_00);
    r10_s = OPW'(sp.rot_10);
    r20_s = OPW'(sp.rot_20);
    r21_s = OPW'(sp.rot_21);
    r22_s = OPW'(sp.rot_22);
    ly[0] = -r20_s; lx[0] = -c_s;
    ly[1] = -r20_s; lx[1] = c_s;
    ly[2] = -r21_s; lx[2] = -r22_s;
    ly[3] = r21_s;  lx[3] = r22_s;
    ly[4] = -r10_s; lx[4] = -r00_s;
    ly[5] = r10_s;  lx[5] = r00_s;
  end

  // cordic chains
  logic signed [W-1:0] x_w [LANES][N+1];
  logic signed [W-1:0] y_w [LANES][N+1];
  logic [Z_W-1:0] z_w [LANES][N+1];
  logic zero_w [LANES][N+1];
  logic signed [ANG_W-1:0] ang [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [W-1:0] xe;
    logic signed [W-1:0] ye;
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
    logic [Z_W-1:0] z0;
    logic zero0;
    logic [Z_W-1:0] zr;

    // pre-rotation by pi for a negative x
    always_comb begin
      xe = W'(lx[l]) <<< 16;
      ye = W'(ly[l]) <<< 16;
      zero0 = (lx[l] == '0) && (ly[l] == '0);
      if (lx[l][OPW-1]) begin
        x0 = -xe;
        y0 = -ye;
        z0 = Z_PI;
      end else begin
        x0 = xe;
        y0 = ye;
        z0 = '0;
      end
    end

    assign x_w[l][0] = x0;
    assign y_w[l][0] = y0;
    assign z_w[l][0] = z0;
    assign zero_w[l][0] = zero0;

    for (genvar i = 0; i < N; i++) begin : g_stage
      rte_cordic_cell #(.W(W), .I(i)) u_cell (
        .clk(clk), .en(adv),
        .x_in(x_w[l][i]), .y_in(y_w[l][i]), .z_in(z_w[l][i]), .zero_in(zero_w[l][i]),
        .x_r(x_w[l][i+1]), .y_r(y_w[l][i+1]), .z_r(z_w[l][i+1]), .zero_r(zero_w[l][i+1])
      );
    end

    // round to the binary angle
    assign zr = z_w[l][N] + Z_HALF_LSB;
    assign ang[l] = zero_w[l][N] ? '0 : $signed(zr[Z_W-1:Z_W-ANG_W]);
  end

  // translation delay matching the cordic chains
  rte_pos_t pos_dly_r [N];

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_dly_r[0] <= '{pos_x: sp.pos_x, pos_y: sp.pos_y, pos_z: sp.pos_z};
      for (int i = 1; i < N; i++) begin
        pos_dly_r[i] <= pos_dly_r[i-1];
      end
    end
  end

  // solution choice on absolute pitch
  logic [ANG_W:0] a1;
  logic [ANG_W:0] a2;
  logic first;

  always_comb begin
    a1 = ang[0][ANG_W-1] ? -{ang[0][ANG_W-1], ang[0]} : {ang[0][ANG_W-1], ang[0]};
    a2 = ang[1][ANG_W-1] ? -{ang[1][ANG_W-1], ang[1]} : {ang[1][ANG_W-1], ang[1]};
    first = a1 < a2;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.pitch_out <= first ? ang[0] : ang[1];
      out_ch.roll_out <= first ? ang[2] : ang[3];
      out_ch.yaw_out <= first ? ang[4] : ang[5];
      out_ch.chose_first <= first;
      out_ch.pos_x_out <= pos_dly_r[N-1].pos_x;
      out_ch.pos_y_out <= pos_dly_r[N-1].pos_y;
      out_ch.pos_z_out <= pos_dly_r[N-1].pos_z;
    end
  end

  assign out_ch.valid = out_valid_r;

  // checks
  `RTE_ASSERT_NEXT(a_in_enters, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0], "lost at entry")
  `RTE_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !adv, $stable(vld_r), "moved while stalled")
  `RTE_ASSERT_SAME(a_out_source, clk, rst_n, $rose(out_ch.valid), $past(vld_r[L-1]), "stray result")

endmodule

FILE: tb/tb_rotation_to_euler_zyx.sv
// ----------------------------------------------------------------------------
// tb_rotation_to_euler_zyx
// self-checking bench for the zyx euler extraction block
// ----------------------------------------------------------------------------
// A queue of poses feeds a clocked driver with random gaps. A clocked monitor
// takes results under a random ready, with one long hold-off, and compares
// each one field by field with the result the bench works out itself.
`timescale 1ns / 1ps

module tb_rotation_to_euler_zyx;
  import rte_pkg::*;

  typedef struct {
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic first;
  } euler_t;

  localparam int STAGES = DEF_CORDIC_STAGES;
  localparam int FRAC = DEF_MATRIX_FRAC_BITS;
  localparam int LATENCY = FRAC + STAGES + 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rte_in_if in_ch ();
  rte_out_if out_ch ();

  rotation_to_euler_zyx dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  rte_payload_t pose_q[$];
  euler_t euler_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  int hold_off = 0;
  int rx_count = 0;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // arctangent table
  function automatic logic [31:0] atan_step(int i);
    logic [31:0] tab[32];
    tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
            32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
            32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326,
            32'd163, 32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1,
            32'd0};
    return tab[i];
  endfunction

  // vectoring cordic angle, 16-bit binary angle
  function automatic logic signed [15:0] bin_angle(longint y, longint x);
    logic [31:0] z;
    longint xs;
    longint ys;
    logic [31:0] r;
    z = 32'd0;
    if (x == 0 && y == 0) return 16'sd0;
    x = x * 64'sd65536;
    y = y * 64'sd65536;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end
    end
    r = (z + 32'h8000) >> 16;
    return r[15:0];
  endfunction

  // floor square root
  function automatic longint floor_sqrt(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
        r = r + (longint'(1) << b);
    end
    return r;
  endfunction

  // both solutions, pick the smaller absolute pitch
  function automatic euler_t solve_euler(rte_payload_t p);
    euler_t e;
    longint r20;
    longint sq;
    longint one2;
    longint c;
    int p1;
    int p2;
    int a1;
    int a2;
    r20 = longint'(p.rot_20);
    one2 = longint'(1) << (2 * FRAC);
    sq = r20 * r20;
    c = floor_sqrt((sq >= one2) ? longint'(0) : one2 - sq);
    p1 = int'(bin_angle(-r20, -c));
    p2 = int'(bin_angle(-r20, c));
    a1 = p1 < 0 ? -p1 : p1;
    a2 = p2 < 0 ? -p2 : p2;
    e.first = a1 < a2;
    if (e.first) begin
      e.pitch = 16'(p1);
      e.roll = bin_angle(-longint'(p.rot_21), -longint'(p.rot_22));
      e.yaw = bin_angle(-longint'(p.rot_10), -longint'(p.rot_00));
    end else begin
      e.pitch = 16'(p2);
      e.roll = bin_angle(longint'(p.rot_21), longint'(p.rot_22));
      e.yaw = bin_angle(longint'(p.rot_10), longint'(p.rot_00));
    end
    e.px = p.pos_x;
    e.py = p.pos_y;
    e.pz = p.pos_z;
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic logic signed [15:0] rand_entry();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'(signed'($urandom_range(0, 65535)));
    if (k == 1) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic rte_payload_t make_pose(logic signed [15:0] r00,
      logic signed [15:0] r10, logic signed [15:0] r20, logic signed [15:0] r21,
      logic signed [15:0] r22);
    rte_payload_t p;
    p.rot_00 = r00;
    p.rot_10 = r10;
    p.rot_20 = r20;
    p.rot_21 = r21;
    p.rot_22 = r22;
    p.pos_x = $urandom;
    p.pos_y = $urandom;
    p.pos_z = $urandom;
    return p;
  endfunction

  // stimulus
  initial begin
    rte_payload_t p;
    pose_q.push_back(make_pose(0, 0, 0, 0, 0));
    pose_q.push_back(make_pose(16384, 0, 0, 0, 16384));
    pose_q.push_back(make_pose(-16384, 0, 0, 0, -16384));
    pose_q.push_back(make_pose(0, 16384, 16384, 0, 0));
    pose_q.push_back(make_pose(0, -16384, -16384, 0, 0));
    pose_q.push_back(make_pose(16384, 16384, 16384, 16384, 16384));
    pose_q.push_back(make_pose(-16384, -16384, -16384, -16384, -16384));
    pose_q.push_back(make_pose(-32768, 32767, 32767, -32768, 32767));
    pose_q.push_back(make_pose(32767, -32768, -32768, 32767, -32768));
    pose_q.push_back(make_pose(-16384, 0, 0, 0, 0));
    pose_q.push_back(make_pose(0, 0, 0, -16384, 0));
    pose_q.push_back(make_pose(11585, 11585, 8192, -11585, 11585));
    pose_q.push_back(make_pose(-1, -1, -1, -1, -1));
    pose_q.push_back(make_pose(1, 1, 1, 1, 1));
    p = make_pose(0, 0, 0, 0, 0);
    p.pos_x = 32'h8000_0000;
    p.pos_y = 32'h7fff_ffff;
    p.pos_z = 32'hffff_ffff;
    pose_q.push_back(p);
    p.pos_x = 32'h7fff_ffff;
    p.pos_y = 32'h8000_0000;
    p.pos_z = 32'h0;
    pose_q.push_back(p);
    for (int n = 0; n < 1150; n++)
      pose_q.push_back(make_pose(rand_entry(), rand_entry(), rand_entry(),
                                 rand_entry(), rand_entry()));
  end

  // reset and finish
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && euler_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // driver
  int send_gap = 0;
  initial begin
    in_ch.valid = 1'b0;
    {in_ch.rot_00, in_ch.rot_10, in_ch.rot_20, in_ch.rot_21, in_ch.rot_22} = '0;
    {in_ch.pos_x_in, in_ch.pos_y_in, in_ch.pos_z_in} = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        euler_q.push_back(solve_euler(pose_q.pop_front()));
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 2) == 0) send_gap = 0;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the current transaction
      end else if (pose_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
      end else if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.rot_00 <= pose_q[0].rot_00;
        in_ch.rot_10 <= pose_q[0].rot_10;
        in_ch.rot_20 <= pose_q[0].rot_20;
        in_ch.rot_21 <= pose_q[0].rot_21;
        in_ch.rot_22 <= pose_q[0].rot_22;
        in_ch.pos_x_in <= pose_q[0].pos_x;
        in_ch.pos_y_in <= pose_q[0].pos_y;
        in_ch.pos_z_in <= pose_q[0].pos_z;
      end
    end
  end

  // long receiver hold-off after a few hundred results
  always @(posedge clk) begin
    if (rx_count == 300 && hold_off == 0) hold_off <= 200;
    else if (hold_off > 1) hold_off <= hold_off - 1;
  end

  // monitor
  int recv_gap = 0;
  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    euler_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        rx_count <= rx_count + 1;
        if (euler_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          e = euler_q.pop_front();
          if (out_ch.roll_out !== e.roll)
            report_mismatch("roll", longint'(out_ch.roll_out), longint'(e.roll));
          if (out_ch.pitch_out !== e.pitch)
            report_mismatch("pitch", longint'(out_ch.pitch_out), longint'(e.pitch));
          if (out_ch.yaw_out !== e.yaw)
            report_mismatch("yaw", longint'(out_ch.yaw_out), longint'(e.yaw));
          if (out_ch.pos_x_out !== e.px)
            report_mismatch("pos_x", longint'(out_ch.pos_x_out), longint'(e.px));
          if (out_ch.pos_y_out !== e.py)
            report_mismatch("pos_y", longint'(out_ch.pos_y_out), longint'(e.py));
          if (out_ch.pos_z_out !== e.pz)
            report_mismatch("pos_z", longint'(out_ch.pos_z_out), longint'(e.pz));
          if (out_ch.chose_first !== e.first)
            report_mismatch("chose_first", longint'(out_ch.chose_first),
                            longint'(e.first));
        end
        recv_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 2) == 0) recv_gap = 0;
      end
      if (hold_off > 1) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        out_ch.ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

endmodule
